/* design/strict_base64_decoder_assert.svh */
// assertion macros for the strict base64 decoder
// expects signals named clock and reset in the including module
`ifndef STRICT_BASE64_DECODER_ASSERT_SVH
`define STRICT_BASE64_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define B64D_ASSERT_NOW(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |-> (con)) else $error(msg);

// next-cycle implication, checked outside reset
`define B64D_ASSERT_NEXT(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) else $error(msg);

`endif

/* design/b64d_pkg.sv */
// shared types, codes and symbol decode for the strict base64 decoder
// no dependencies
package b64d_pkg;

   typedef enum logic {
      REQ_CHAR = 1'b0,
      REQ_END  = 1'b1
   } req_kind_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } out_kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_CHAR     = 3'd1,
      ST_EXCESS_PAD   = 3'd2,
      ST_AFTER_PAD    = 3'd3,
      ST_MIXED        = 3'd4,
      ST_LONE_CHAR    = 3'd5,
      ST_LEFTOVER     = 3'd6,
      ST_PAD_MISMATCH = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      ALPHA_NONE = 2'd0,
      ALPHA_STD  = 2'd1,
      ALPHA_URL  = 2'd2
   } alphabet_type;

   localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
   localparam logic [7:0] CHAR_LF  = 8'h0A;
   localparam logic [7:0] CHAR_CR  = 8'h0D;
   localparam logic [7:0] CHAR_SP  = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_FF  = 8'h0C;

   localparam logic [5:0] SYM_LOWER_BASE = 6'd26;
   localparam logic [5:0] SYM_DIGIT_BASE = 6'd52;
   localparam logic [5:0] SYM_62         = 6'd62;
   localparam logic [5:0] SYM_63         = 6'd63;

   typedef struct packed {
      out_kind_type kind;
      logic [7:0]   data;
      status_type   status;
   } result_type;

   typedef struct packed {
      logic         valid;
      logic [5:0]   sym;
      alphabet_type alpha;
   } sym_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_LF) || (c == CHAR_CR) || (c == CHAR_SP) ||
             (c == CHAR_TAB) || (c == CHAR_FF);
   endfunction

   function automatic sym_type decode_char(input logic [7:0] c);
      sym_type d;
      d.valid = 1'b1;
      d.alpha = ALPHA_NONE;
      d.sym   = '0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         d.sym = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d.sym = 6'(c - 8'h61) + SYM_LOWER_BASE;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d.sym = 6'(c - 8'h30) + SYM_DIGIT_BASE;
      end else if (c == 8'h2B) begin
         d.sym   = SYM_62;
         d.alpha = ALPHA_STD;
      end else if (c == 8'h2F) begin
         d.sym   = SYM_63;
         d.alpha = ALPHA_STD;
      end else if (c == 8'h2D) begin
         d.sym   = SYM_62;
         d.alpha = ALPHA_URL;
      end else if (c == 8'h5F) begin
         d.sym   = SYM_63;
         d.alpha = ALPHA_URL;
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

   // any of the low n bits of b set
   function automatic logic has_leftover(input logic [11:0] b, input logic [2:0] n);
      logic [11:0] mask;
      mask = (12'd1 << n) - 12'd1;
      return |(b & mask);
   endfunction

endpackage

/* design/b64d_core.sv */
// decode state and single-step update logic of the strict base64 decoder
// depends on b64d_pkg
module b64d_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  b64d_pkg::req_kind_type step_kind,
   input  logic [7:0]           step_char,
   output logic                 emit,
   output b64d_pkg::result_type result
);

   logic [11:0]            buf_ff, buf_in;
   logic [2:0]             cnt_ff, cnt_in;
   b64d_pkg::alphabet_type alpha_ff, alpha_in;
   logic [1:0]             sym_cnt_ff, sym_cnt_in;
   logic [1:0]             pad_ff, pad_in;
   b64d_pkg::status_type   err_ff, err_in;

   b64d_pkg::sym_type      dec;
   logic [3:0]             cnt_sum;
   logic [2:0]             pad_total;

   always_comb begin
      dec        = b64d_pkg::decode_char(step_char);
      cnt_sum    = {1'b0, cnt_ff} + 4'd6;
      pad_total  = {1'b0, sym_cnt_ff} + {1'b0, pad_ff};
      buf_in     = buf_ff;
      cnt_in     = cnt_ff;
      alpha_in   = alpha_ff;
      sym_cnt_in = sym_cnt_ff;
      pad_in     = pad_ff;
      err_in     = err_ff;
      emit          = 1'b0;
      result.kind   = b64d_pkg::KIND_DATA;
      result.data   = '0;
      result.status = b64d_pkg::ST_OK;

      if (step_kind == b64d_pkg::REQ_END) begin
         emit          = 1'b1;
         result.kind   = b64d_pkg::KIND_STATUS;
         result.status = err_ff;
         if (err_ff == b64d_pkg::ST_OK) begin
            if (cnt_ff >= 3'd6) begin
               result.status = b64d_pkg::ST_LONE_CHAR;
            end else if (b64d_pkg::has_leftover(buf_ff, cnt_ff)) begin
               result.status = b64d_pkg::ST_LEFTOVER;
            end else if (pad_ff != 2'd0 && pad_total != 3'd4) begin
               result.status = b64d_pkg::ST_PAD_MISMATCH;
            end
         end
         buf_in     = '0;
         cnt_in     = '0;
         alpha_in   = b64d_pkg::ALPHA_NONE;
         sym_cnt_in = '0;
         pad_in     = '0;
         err_in     = b64d_pkg::ST_OK;
      end else if (err_ff != b64d_pkg::ST_OK || b64d_pkg::is_space(step_char)) begin
         // latched error or whitespace: no effect
      end else if (step_char == b64d_pkg::CHAR_PAD) begin
         if (pad_ff >= 2'd2) begin
            err_in = b64d_pkg::ST_EXCESS_PAD;
         end else begin
            pad_in = pad_ff + 2'd1;
         end
      end else if (pad_ff != 2'd0) begin
         err_in = b64d_pkg::ST_AFTER_PAD;
      end else if (!dec.valid) begin
         err_in = b64d_pkg::ST_BAD_CHAR;
      end else if (dec.alpha != b64d_pkg::ALPHA_NONE &&
                   alpha_ff != b64d_pkg::ALPHA_NONE && alpha_ff != dec.alpha) begin
         err_in = b64d_pkg::ST_MIXED;
      end else begin
         if (dec.alpha != b64d_pkg::ALPHA_NONE) begin
            alpha_in = dec.alpha;
         end
         sym_cnt_in = sym_cnt_ff + 2'd1;
         buf_in     = {buf_ff[5:0], dec.sym};
         if (cnt_sum >= 4'd8) begin
            cnt_in      = 3'(cnt_sum - 4'd8);
            emit        = 1'b1;
            result.data = 8'(buf_in >> cnt_in);
         end else begin
            cnt_in = cnt_sum[2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff     <= '0;
         cnt_ff     <= '0;
         alpha_ff   <= b64d_pkg::ALPHA_NONE;
         sym_cnt_ff <= '0;
         pad_ff     <= '0;
         err_ff     <= b64d_pkg::ST_OK;
      end else if (step_en) begin
         buf_ff     <= buf_in;
         cnt_ff     <= cnt_in;
         alpha_ff   <= alpha_in;
         sym_cnt_ff <= sym_cnt_in;
         pad_ff     <= pad_in;
         err_ff     <= err_in;
      end
   end

endmodule

/* design/strict_base64_decoder.sv */
// top level of the strict base64 decoder: input register, decode core, result register
// depends on b64d_pkg, b64d_core and strict_base64_decoder_assert.svh
`include "strict_base64_decoder_assert.svh"

// Strict base64 decoder. Each req beat carries one character (req_tuser = 0)
// or an end-of-text marker (req_tuser = 1). Whitespace is skipped, '=' is
// counted as padding, and standard or URL-safe symbols are shifted into a
// small accumulator; a data rsp beat (rsp_tuser = 0) leaves each time eight
// bits are complete. The first error in a text is latched and suppresses
// further data beats. Every end beat yields exactly one status rsp beat
// (rsp_tuser = 1) and returns the decoder to its empty state; a nonzero
// status means the data beats of that text must be dropped. Rate: one
// character per clock while the result register is free or being drained;
// the decode-and-shift step sits between the input and result registers. An
// accepted req beat waits in the input register until the core steps it and
// loads the result register, which needs it free or draining. req_tready
// stays high while the result register is free or being drained this cycle.
module strict_base64_decoder (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // [0] req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [10:8] status, [15:11] zero
   output logic        rsp_tuser    // [0] out_kind
);

   // input register
   logic                        in_valid_ff, in_valid_in;
   b64d_pkg::req_kind_type      in_kind_ff;
   logic [7:0]                  in_char_ff;

   // result register
   logic                        out_valid_ff, out_valid_in;
   b64d_pkg::result_type        out_ff;

   logic                        advance;    // input item consumed by the core this cycle
   logic                        req_take;
   logic                        emit;
   b64d_pkg::result_type        result;

   // the core may step when the result register is empty or being read out
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance ? emit : (out_valid_ff && !rsp_tready);

   b64d_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_kind (in_kind_ff),
      .step_char (in_char_ff),
      .emit      (emit),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= b64d_pkg::req_kind_type'(req_tuser);
         in_char_ff <= req_tdata;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tdata  = {5'b0, out_ff.status, out_ff.data};

   // a held input item is never overwritten before the core takes it
   `B64D_ASSERT_NEXT(a_in_hold, in_valid_ff && !advance,
      in_valid_ff && $stable(in_char_ff) && $stable(in_kind_ff), "input item lost")
   // a stalled result is never overwritten
   `B64D_ASSERT_NEXT(a_out_hold, out_valid_ff && !rsp_tready,
      out_valid_ff && $stable(out_ff), "stalled result overwritten")
   // every end item produces a status result
   `B64D_ASSERT_NOW(a_end_status, advance && in_kind_ff == b64d_pkg::REQ_END,
      emit && result.kind == b64d_pkg::KIND_STATUS, "end item without status")
   // data results never carry a status code
   `B64D_ASSERT_NOW(a_data_clean, advance && emit && result.kind == b64d_pkg::KIND_DATA,
      result.status == b64d_pkg::ST_OK, "data result with status")

endmodule

/* tb/sv/strict_base64_decoder_checker.sv */
// stream checker for the strict base64 decoder: decodes each accepted req beat on its own
// and compares every rsp beat with the oldest awaited one; depends on b64d_pkg
module strict_base64_decoder_checker
   import b64d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          mismatches,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   // decoder state as seen from outside
   logic [11:0]  acc_bits;
   int           acc_count;
   alphabet_type text_alpha;
   int           sym_mod4;
   int           pad_seen;
   status_type   first_error;

   result_type   awaited_beats[$];
   int           fail_count = 0;

   assign mismatches = fail_count;
   initial outstanding = 0;

   task automatic flag_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void clear_text();
      acc_bits    = '0;
      acc_count   = 0;
      text_alpha  = ALPHA_NONE;
      sym_mod4    = 0;
      pad_seen    = 0;
      first_error = ST_OK;
   endfunction

   // 6-bit value of a base64 character, and which alphabet it belongs to
   function automatic logic lookup_symbol(input logic [7:0] c, output logic [5:0] sym,
                                          output alphabet_type alpha);
      alpha = ALPHA_NONE;
      sym   = '0;
      if (c >= "A" && c <= "Z") sym = 6'(c - "A");
      else if (c >= "a" && c <= "z") sym = 6'(c - "a" + 8'd26);
      else if (c >= "0" && c <= "9") sym = 6'(c - "0" + 8'd52);
      else if (c == "+") begin sym = 6'd62; alpha = ALPHA_STD; end
      else if (c == "/") begin sym = 6'd63; alpha = ALPHA_STD; end
      else if (c == "-") begin sym = 6'd62; alpha = ALPHA_URL; end
      else if (c == "_") begin sym = 6'd63; alpha = ALPHA_URL; end
      else return 1'b0;
      return 1'b1;
   endfunction

   // advance the state by one req beat; returns 1 when a rsp beat is due
   function automatic logic decode_step(input logic is_end, input logic [7:0] c,
                                        output result_type r);
      logic [5:0]   sym;
      alphabet_type alpha;
      status_type   st;
      r.kind   = KIND_DATA;
      r.data   = 8'h00;
      r.status = ST_OK;
      if (is_end) begin
         st = first_error;
         if (st == ST_OK) begin
            if (acc_count >= 6) st = ST_LONE_CHAR;
            else if ((acc_bits & ((12'd1 << acc_count) - 12'd1)) != 12'd0) st = ST_LEFTOVER;
            else if (pad_seen > 0 && sym_mod4 + pad_seen != 4) st = ST_PAD_MISMATCH;
         end
         r.kind   = KIND_STATUS;
         r.status = st;
         clear_text();
         return 1'b1;
      end
      if (first_error != ST_OK) return 1'b0;
      if (c == CHAR_LF || c == CHAR_CR || c == CHAR_SP || c == CHAR_TAB || c == CHAR_FF)
         return 1'b0;
      if (c == CHAR_PAD) begin
         if (pad_seen >= 2) first_error = ST_EXCESS_PAD;
         else pad_seen++;
         return 1'b0;
      end
      if (pad_seen > 0) begin
         first_error = ST_AFTER_PAD;
         return 1'b0;
      end
      if (!lookup_symbol(c, sym, alpha)) begin
         first_error = ST_BAD_CHAR;
         return 1'b0;
      end
      if (alpha != ALPHA_NONE) begin
         if (text_alpha != ALPHA_NONE && text_alpha != alpha) begin
            first_error = ST_MIXED;
            return 1'b0;
         end
         text_alpha = alpha;
      end
      sym_mod4  = (sym_mod4 + 1) % 4;
      acc_bits  = {acc_bits[5:0], sym};
      acc_count = acc_count + 6;
      if (acc_count >= 8) begin
         acc_count = acc_count - 8;
         r.data    = 8'(acc_bits >> acc_count);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_text();
         awaited_beats.delete();
      end else begin
         // rsp first: a beat accepted now always stems from an earlier req
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_beats.size() == 0) begin
               flag_mismatch($sformatf("unexpected rsp beat: kind %0d data %02h status %0d",
                                       rsp_tuser, rsp_tdata[7:0], rsp_tdata[10:8]));
            end else begin
               want = awaited_beats.pop_front();
               if (rsp_tuser != want.kind)
                  flag_mismatch($sformatf("kind: got %0d, want %0d", rsp_tuser, want.kind));
               if (rsp_tdata[7:0] != want.data)
                  flag_mismatch($sformatf("data byte: got %02h, want %02h",
                                          rsp_tdata[7:0], want.data));
               if (rsp_tdata[10:8] != want.status)
                  flag_mismatch($sformatf("status: got %0d, want %0d",
                                          rsp_tdata[10:8], want.status));
               if (rsp_tdata[15:11] != 5'd0)
                  flag_mismatch($sformatf("fill bits: got %02h, want 0", rsp_tdata[15:11]));
            end
         end
         if (req_tvalid && req_tready) begin
            if (decode_step(req_tuser == REQ_END, req_tdata, want))
               awaited_beats.insert(awaited_beats.size(), want);
         end
      end
      outstanding <= awaited_beats.size();
   end

endmodule

/* tb/sv/strict_base64_decoder_tb.sv */
// top of the strict base64 decoder testbench: clock, reset, req and rsp stimulus, verdict
// depends on b64d_pkg, strict_base64_decoder and strict_base64_decoder_checker
module strict_base64_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import b64d_pkg::*;

   localparam int ITEM_TARGET = 800;
   // slowest run: ~900 beats, each with its drawn idle gap on req and stall on rsp;
   // the limit covers that many times over
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] char_code
   logic        req_tuser  = 1'b0;    // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [7:0] data_byte, [10:8] status, [15:11] zero
   logic        rsp_tuser;            // [0] out_kind

   int          mismatches;
   int          outstanding;
   int          cycle_count   = 0;
   int          counted_items = 0;
   bit          tx_calm       = 1'b0;  // no idle cycles on req while set
   bit          rx_calm       = 1'b0;  // no stall cycles on rsp while set
   logic [7:0]  chars[$];              // characters of the text being built

   always #5 clock = ~clock;

   strict_base64_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   strict_base64_decoder_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // character of a 6-bit symbol in the chosen alphabet
   function automatic logic [7:0] sym_char(input logic [5:0] s, input bit url);
      if (s < 6'd26) return "A" + 8'(s);
      if (s < 6'd52) return "a" + 8'(s) - 8'd26;
      if (s < 6'd62) return "0" + 8'(s) - 8'd52;
      if (s == 6'd62) return url ? "-" : "+";
      return url ? "_" : "/";
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 4))
         0: return CHAR_LF;
         1: return CHAR_CR;
         2: return CHAR_SP;
         3: return CHAR_TAB;
         default: return CHAR_FF;
      endcase
   endfunction

   // one req beat; valid stays high straight into the next beat when no idle is drawn
   task automatic push_beat(input req_kind_type k, input logic [7:0] c);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // whitespace is skipped by the block, so it does not count
      if (k == REQ_END || !(c == CHAR_LF || c == CHAR_CR || c == CHAR_SP ||
                            c == CHAR_TAB || c == CHAR_FF))
         counted_items++;
   endtask

   // send the built text followed by its end beat; the end beat carries random junk
   task automatic send_text();
      foreach (chars[i]) push_beat(REQ_CHAR, chars[i]);
      push_beat(REQ_END, 8'($urandom));
      chars.delete();
   endtask

   // hold req low until every awaited rsp beat has come
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // one character at the end of the text being built
   task automatic append_char(input logic [7:0] c);
      chars.insert(chars.size(), c);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) append_char(s[i]);
   endtask

   task automatic add_char(input logic [7:0] c, input int blank_pct);
      if ($urandom_range(0, 99) < blank_pct) append_char(pick_blank());
      append_char(c);
   endtask

   // base64 text of a random payload, optionally padded, optionally sprinkled with blanks
   task automatic add_encoded(input int nbytes, input bit url, input bit padded,
                              input int blank_pct);
      logic [7:0]  payload[$];
      logic [23:0] group;
      int          left;
      int          nsym;
      for (int i = 0; i < nbytes; i++) payload.insert(payload.size(), 8'($urandom));
      for (int i = 0; i < nbytes; i += 3) begin
         left  = nbytes - i;
         group = {payload[i], (left > 1) ? payload[i+1] : 8'h00,
                  (left > 2) ? payload[i+2] : 8'h00};
         nsym  = (left >= 3) ? 4 : left + 1;
         for (int k = 0; k < 4; k++) begin
            if (k < nsym) add_char(sym_char(group[23-6*k -: 6], url), blank_pct);
            else if (padded) add_char(CHAR_PAD, blank_pct);
         end
      end
   endtask

   // rsp side: a fresh stall per beat, with calm stretches every 32 beats
   initial begin
      int stall;
      int beats_taken;
      beats_taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (beats_taken % 32 == 0) rx_calm = ($urandom_range(0, 3) == 0);
         stall = rx_calm ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         beats_taken++;
      end
   end

   initial begin
      int  pick;
      int  pos;
      bit  url;
      bit  padded;
      int  blank_pct;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed texts
      send_text();                                   // empty text
      append_char(CHAR_LF);                          // "TQ==" wrapped in every blank
      append_char("T");
      append_char(CHAR_TAB);
      append_char("Q");
      append_char(CHAR_CR);
      append_char(CHAR_PAD);
      append_char(CHAR_FF);
      append_char(CHAR_PAD);
      append_char(CHAR_SP);
      send_text();
      add_str("T");     send_text();                 // lone leftover character
      add_str("TR");    send_text();                 // nonzero leftover bits
      add_str("===");   send_text();                 // third padding
      add_str("=A");    send_text();                 // symbol after padding
      add_str("-/");    send_text();                 // mixed alphabets
      append_char(8'hFF); send_text();               // invalid byte above 127
      add_str("=");     send_text();                 // padding with no symbols
      drain();                                       // let everything come back once

      // random texts
      while (counted_items < ITEM_TARGET) begin
         tx_calm   = ($urandom_range(0, 3) == 0);
         url       = 1'($urandom_range(0, 1));
         padded    = ($urandom_range(0, 3) != 0);
         blank_pct = ($urandom_range(0, 3) == 0) ? 15 : 0;
         pick      = $urandom_range(0, 99);
         if (pick < 90) begin
            add_encoded($urandom_range(0, 9), url, padded, blank_pct);
            if (pick >= 70) begin
               // break an otherwise well-formed text
               pos = (chars.size() > 0) ? $urandom_range(0, chars.size() - 1) : 0;
               case ($urandom_range(0, 5))
                  0: chars.insert(pos, 8'($urandom));
                  1: append_char(CHAR_PAD);
                  2: append_char(sym_char(6'($urandom), url));
                  3: chars.insert(pos, sym_char(6'd62 + 6'($urandom_range(0, 1)), !url));
                  4: if (chars.size() > 0) chars.delete(pos);
                  default: if (chars.size() > 0) chars[chars.size() - 1] =
                     sym_char(6'($urandom), url);
               endcase
            end
         end else begin
            // noise: raw bytes mixed with symbols, padding and blanks
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 3))
                  0: append_char(8'($urandom));
                  1: append_char(CHAR_PAD);
                  2: append_char(pick_blank());
                  default: append_char(sym_char(6'($urandom), 1'($urandom_range(0, 1))));
               endcase
            end
         end
         send_text();
         if ($urandom_range(0, 15) == 0) drain();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/b64d_pkg.sv
design/b64d_core.sv
design/strict_base64_decoder.sv
tb/sv/strict_base64_decoder_checker.sv
tb/sv/strict_base64_decoder_tb.sv
